// ===== rtl/rht_pkg.sv =====
package rht_pkg;

   localparam int NUM_REGIONS = 32;
   localparam int CELL_W      = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
   localparam int SLOT_W      = 5;
   localparam int COORD_W     = 12;
   localparam int SQ_W        = 2 * COORD_W;
   localparam int CMP_W       = (CELL_W > SLOT_W) ? CELL_W : SLOT_W;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 8;

   localparam logic [1:0] OP_CIRCLE = 2'd0;
   localparam logic [1:0] OP_RECT   = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   typedef enum logic [1:0] {
      KIND_EMPTY  = 2'd0,
      KIND_CIRCLE = 2'd1,
      KIND_RECT   = 2'd2
   } kind_type;

   // Query point travelling down the chain with the best match so far
   typedef struct packed {
      logic               valid;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic               hit;
      logic [SLOT_W-1:0]  idx;
   } token_type;

   // Region load broadcast to every cell
   typedef struct packed {
      logic               en;
      logic [SLOT_W-1:0]  slot;
      kind_type           kind;
      logic [COORD_W-1:0] ax;
      logic [COORD_W-1:0] ay;
      logic [COORD_W-1:0] bx;
      logic [COORD_W-1:0] by;
   } wr_type;

endpackage

// ===== rtl/region_hit_tester_unit.sv =====
// Region writes may follow back to back while no query is in flight and the skid entry is empty.
// A query walks a chain of NUM_REGIONS cells, each registering a square stage
// and then a sum-and-compare stage; its response is registered after the
// last cell, and no new request is taken until the token leaves that cell.
// Synchronous active-high reset marks every region empty and drops any
// request in flight; no clearing pass is needed.
module region_hit_tester_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // opcode[1:0] slot[6:2] point_x[18:7] point_y[30:19] far_x[42:31]
   // far_y[54:43] radius[66:55], zero pad [71:67]
   input  logic [rht_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hit[0] region_index[5:1], zero pad [7:6]
   output logic [rht_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import rht_pkg::*;

   logic [1:0]          op;
   logic [SLOT_W-1:0]   slot;
   logic [COORD_W-1:0]  px, py, fx, fy, rad;
   logic                accept;

   wr_type              wr;
   token_type           tok [NUM_REGIONS+1];

   logic                busy_ff, busy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic                skid_valid_ff, skid_valid_in;
   logic                skid_hit_ff, skid_hit_in;
   logic [SLOT_W-1:0]   skid_idx_ff, skid_idx_in;

   assign op   = req_tdata[1:0];
   assign slot = req_tdata[6:2];
   assign px   = req_tdata[18:7];
   assign py   = req_tdata[30:19];
   assign fx   = req_tdata[42:31];
   assign fy   = req_tdata[54:43];
   assign rad  = req_tdata[66:55];

   assign req_tready = !busy_ff && !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      wr.en   = accept && ((op == OP_CIRCLE) || (op == OP_RECT));
      wr.slot = slot;
      wr.kind = (op == OP_CIRCLE) ? KIND_CIRCLE : KIND_RECT;
      wr.ax   = px;
      wr.ay   = py;
      wr.bx   = (op == OP_CIRCLE) ? rad : fx;
      wr.by   = (op == OP_CIRCLE) ? '0 : fy;
   end

   always_comb begin
      tok[0].valid = accept && (op == OP_QUERY);
      tok[0].px    = px;
      tok[0].py    = py;
      tok[0].hit   = 1'b0;
      tok[0].idx   = '0;
   end

   for (genvar i = 0; i < NUM_REGIONS; i++) begin : g_cell
      rht_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (CELL_W'(i)),
         .wr         (wr),
         .tok_in     (tok[i]),
         .tok_out    (tok[i+1])
      );
   end

   // Busy from query acceptance until the token leaves the last cell
   always_comb begin
      busy_in = busy_ff;
      if (tok[0].valid) begin
         busy_in = 1'b1;
      end else if (tok[NUM_REGIONS].valid) begin
         busy_in = 1'b0;
      end
   end

   // Output register with one skid entry for a response that finds it full
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_idx_in    = rsp_idx_ff;
      skid_valid_in = skid_valid_ff;
      skid_hit_in   = skid_hit_ff;
      skid_idx_in   = skid_idx_ff;
      if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_hit_in    = skid_hit_ff;
            rsp_idx_in    = skid_idx_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = tok[NUM_REGIONS].valid;
            rsp_hit_in   = tok[NUM_REGIONS].hit;
            rsp_idx_in   = tok[NUM_REGIONS].idx;
         end
      end else if (tok[NUM_REGIONS].valid) begin
         skid_valid_in = 1'b1;
         skid_hit_in   = tok[NUM_REGIONS].hit;
         skid_idx_in   = tok[NUM_REGIONS].idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff  <= rsp_hit_in;
      rsp_idx_ff  <= rsp_idx_in;
      skid_hit_ff <= skid_hit_in;
      skid_idx_ff <= skid_idx_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_idx_ff, rsp_hit_ff};

endmodule

// ===== rtl/rht_cell.sv =====
module rht_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rht_pkg::CELL_W-1:0]        cell_index,
   input  rht_pkg::wr_type                   wr,
   input  rht_pkg::token_type                tok_in,
   output rht_pkg::token_type                tok_out
);
   import rht_pkg::*;

   kind_type            kind_ff;
   logic [COORD_W-1:0]  ax_ff, ay_ff, bx_ff, by_ff;

   logic                s1_valid_ff;
   token_type           s1_tok_ff;
   logic [SQ_W-1:0]     dx2_ff, dy2_ff, r2_ff;
   logic                rect_ok_ff;

   logic                s2_valid_ff;
   token_type           s2_tok_ff;

   logic                sel;
   logic [COORD_W-1:0]  dx, dy;
   logic                rect_ok;
   logic [SQ_W:0]       dist2;
   logic                match;
   token_type           s2_tok_in;
   logic [SLOT_W-1:0]   my_idx;

   assign sel    = wr.en && (CMP_W'(wr.slot) == CMP_W'(cell_index));
   assign my_idx = SLOT_W'(cell_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_EMPTY;
      end else if (sel) begin
         kind_ff <= wr.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         ax_ff <= wr.ax;
         ay_ff <= wr.ay;
         bx_ff <= wr.bx;
         by_ff <= wr.by;
      end
   end

   // Stage one: distances, squares and the rectangle compare
   always_comb begin
      dx = (tok_in.px >= ax_ff) ? (tok_in.px - ax_ff) : (ax_ff - tok_in.px);
      dy = (tok_in.py >= ay_ff) ? (tok_in.py - ay_ff) : (ay_ff - tok_in.py);
      rect_ok = (tok_in.px >= ax_ff) && (tok_in.px <= bx_ff) &&
                (tok_in.py >= ay_ff) && (tok_in.py <= by_ff);
   end

   always_ff @(posedge clock) begin
      s1_tok_ff  <= tok_in;
      dx2_ff     <= SQ_W'(dx) * SQ_W'(dx);
      dy2_ff     <= SQ_W'(dy) * SQ_W'(dy);
      r2_ff      <= SQ_W'(bx_ff) * SQ_W'(bx_ff);
      rect_ok_ff <= rect_ok;
   end

   // Stage two: finish the circle test and keep the lowest match
   always_comb begin
      dist2 = {1'b0, dx2_ff} + {1'b0, dy2_ff};
      match = ((kind_ff == KIND_CIRCLE) && (dist2 <= {1'b0, r2_ff})) ||
              ((kind_ff == KIND_RECT) && rect_ok_ff);
      s2_tok_in       = s1_tok_ff;
      s2_tok_in.valid = s1_valid_ff;
      if (!s1_tok_ff.hit && match) begin
         s2_tok_in.hit = 1'b1;
         s2_tok_in.idx = my_idx;
      end
   end

   always_ff @(posedge clock) begin
      s2_tok_ff <= s2_tok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= tok_in.valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_comb begin
      tok_out       = s2_tok_ff;
      tok_out.valid = s2_valid_ff;
   end

endmodule

// ===== rtl/rht_checker.sv =====
module rht_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [rht_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rht_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import rht_pkg::*;

   // A stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // A miss reports index zero, and the pad bits stay clear
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] || (rsp_tdata[5:1] == '0)) &&
                     (rsp_tdata[7:6] == 2'b00))
      else $error("miss with nonzero index or pad bits set");

   // A query in flight blocks the next request
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[1:0] == OP_QUERY) |=> !req_tready)
      else $error("request taken while a query is in flight");

   // A request taken while no response is pending yields no response in the following cycle
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response appeared too early");

   // Reset leaves no response pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind region_hit_tester_unit rht_checker u_rht_checker (.*);
